// File: design/pnc_pkg.sv
// Shared types and constants for the palette nearest colour mapper.
// No dependencies; every other file depends on this package.
package pnc_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int FRACTION_BITS = 4;

    localparam int ADDR_W  = $clog2(PALETTE_DEPTH);
    localparam int IDX_W   = 8;
    localparam int CHAN_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int PIX_W   = BYTE_W + FRACTION_BITS;
    localparam int DIFF_W  = (PIX_W > CHAN_W) ? PIX_W : CHAN_W;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int SUM_W   = SQ_W + 4;
    localparam int DIST_W  = 30;
    localparam int CNT_W   = 9;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 1;

    // drain length after the last read issue, until the best register is settled
    localparam int DRAIN_CYCLES = 3;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_PIXEL = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_ENTRIES    = 1'b0,
        REG_PIXELS_HAVE_ALPHA = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic              load_pixel;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              rd_first;
        logic              out_load;
    } pnc_cmd_t;

    typedef struct packed {
        logic out_free;
    } pnc_stat_t;

endpackage

// File: design/pnc_if.sv
// Valid/ready channels for request words and result words.
// Depends on pnc_pkg for field widths.
interface pnc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [pnc_pkg::IDX_W-1:0]     entry_index;
    logic [pnc_pkg::CHAN_W-1:0]    entry_red;
    logic [pnc_pkg::CHAN_W-1:0]    entry_green;
    logic [pnc_pkg::CHAN_W-1:0]    entry_blue;
    logic [pnc_pkg::CHAN_W-1:0]    entry_alpha;
    logic [pnc_pkg::BYTE_W-1:0]    pixel_red;
    logic [pnc_pkg::BYTE_W-1:0]    pixel_green;
    logic [pnc_pkg::BYTE_W-1:0]    pixel_blue;
    logic [pnc_pkg::BYTE_W-1:0]    pixel_alpha;

    modport source (
        output valid, kind, entry_index, entry_red, entry_green, entry_blue, entry_alpha,
        output pixel_red, pixel_green, pixel_blue, pixel_alpha,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, entry_red, entry_green, entry_blue, entry_alpha,
        input  pixel_red, pixel_green, pixel_blue, pixel_alpha,
        output ready
    );
endinterface

interface pnc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pnc_pkg::IDX_W-1:0]     nearest_index;
    logic [pnc_pkg::DIST_W-1:0]    nearest_distance;

    modport source (output valid, nearest_index, nearest_distance, input ready);
    modport sink   (input  valid, nearest_index, nearest_distance, output ready);
endinterface

// File: design/palette_nearest_color_mapper.sv
// Palette nearest colour mapper: top level with configuration registers.
// A palette-write word is taken in the idle state. A pixel word's result word becomes valid
// after a scan of N entries, N being the clamped active entry count, a pipeline drain and
// a wait for a free output register; no new word is taken until that result is loaded.
// The single palette read port and the shared distance pipeline visit one entry a cycle.
// Reset clears control and configuration (256 entries, alpha used); palette contents stay
// undefined until written. Depends on pnc_pkg, pnc_if, pnc_ctrl and pnc_dp.
module palette_nearest_color_mapper (
    input  logic                           clk,
    input  logic                           rst_n,
    pnc_req_if.sink                        req,
    pnc_rsp_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [pnc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pnc_pkg::CFG_W-1:0]      cfg_data
);
    import pnc_pkg::*;

    logic [CNT_W-1:0] active_entries_reg;
    logic             have_alpha_reg;
    pnc_cmd_t         cmd;
    pnc_stat_t        stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_entries_reg <= CNT_W'(PALETTE_DEPTH);
            have_alpha_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ACTIVE_ENTRIES:    active_entries_reg <= cfg_data[CNT_W-1:0];
                REG_PIXELS_HAVE_ALPHA: have_alpha_reg     <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    pnc_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (req.valid),
        .in_kind        (req.kind),
        .in_ready       (req.ready),
        .active_entries (active_entries_reg),
        .stat           (stat),
        .cmd            (cmd)
    );

    pnc_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .pixels_have_alpha (have_alpha_reg),
        .entry_index       (req.entry_index),
        .entry_red         (req.entry_red),
        .entry_green       (req.entry_green),
        .entry_blue        (req.entry_blue),
        .entry_alpha       (req.entry_alpha),
        .pixel_red         (req.pixel_red),
        .pixel_green       (req.pixel_green),
        .pixel_blue        (req.pixel_blue),
        .pixel_alpha       (req.pixel_alpha),
        .out_valid         (rsp.valid),
        .out_ready         (rsp.ready),
        .nearest_index     (rsp.nearest_index),
        .nearest_distance  (rsp.nearest_distance)
    );

endmodule

// File: design/pnc_ctrl.sv
// Controller: accepts request words, sequences the palette scan, loads the result.
// Depends on pnc_pkg.
module pnc_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_kind,
    output logic                       in_ready,
    input  logic [pnc_pkg::CNT_W-1:0]  active_entries,
    input  pnc_pkg::pnc_stat_t         stat,
    output pnc_pkg::pnc_cmd_t          cmd
);
    import pnc_pkg::*;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   last_reg, last_next;
    logic [DRAIN_W-1:0]  drain_reg, drain_next;
    logic [CNT_W-1:0]    count;
    logic                accept;

    // clamp the active count into 1..PALETTE_DEPTH
    always_comb
    begin
        if (active_entries == '0)
            count = CNT_W'(1);
        else if (active_entries > CNT_W'(PALETTE_DEPTH))
            count = CNT_W'(PALETTE_DEPTH);
        else
            count = active_entries;
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
            last_reg  <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            last_reg  <= last_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        drain_next     = drain_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.rd_addr    = addr_reg;
        cmd.rd_first   = (addr_reg == '0);

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    if (kind_t'(in_kind) == KIND_WRITE)
                        cmd.wr_en = 1'b1;
                    else
                    begin
                        cmd.load_pixel = 1'b1;
                        addr_next      = '0;
                        last_next      = ADDR_W'(count - CNT_W'(1));
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (addr_reg == last_reg)
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
                else
                    addr_next = addr_reg + ADDR_W'(1);
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + DRAIN_W'(1);
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register can take the word
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_pixel_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_kind == KIND_PIXEL) |=> (state_reg == ST_SCAN && addr_reg == '0))
        else $error("pixel accept did not start a scan at entry zero");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (addr_reg <= last_reg))
        else $error("scan address ran past the last active entry");

    a_drain_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && drain_reg == DRAIN_W'(DRAIN_CYCLES - 1))
            |=> (state_reg == ST_FINISH))
        else $error("drain did not end after the pipeline depth");

endmodule

// File: design/pnc_dp.sv
// Datapath: palette memory, shared distance pipeline, running minimum, output register.
// Depends on pnc_pkg.
module pnc_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pnc_pkg::pnc_cmd_t           cmd,
    output pnc_pkg::pnc_stat_t          stat,
    input  logic                        pixels_have_alpha,
    input  logic [pnc_pkg::IDX_W-1:0]   entry_index,
    input  logic [pnc_pkg::CHAN_W-1:0]  entry_red,
    input  logic [pnc_pkg::CHAN_W-1:0]  entry_green,
    input  logic [pnc_pkg::CHAN_W-1:0]  entry_blue,
    input  logic [pnc_pkg::CHAN_W-1:0]  entry_alpha,
    input  logic [pnc_pkg::BYTE_W-1:0]  pixel_red,
    input  logic [pnc_pkg::BYTE_W-1:0]  pixel_green,
    input  logic [pnc_pkg::BYTE_W-1:0]  pixel_blue,
    input  logic [pnc_pkg::BYTE_W-1:0]  pixel_alpha,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pnc_pkg::IDX_W-1:0]   nearest_index,
    output logic [pnc_pkg::DIST_W-1:0]  nearest_distance
);
    import pnc_pkg::*;

    localparam int SAT_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [DIFF_W-1:0] a,
                                                input logic [DIFF_W-1:0] b);
        logic [DIFF_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    entry_t              mem [PALETTE_DEPTH];
    entry_t              rd_reg;
    logic [PIX_W-1:0]    pr_reg, pg_reg, pb_reg, pa_reg;
    logic [BYTE_W-1:0]   pa_byte;

    logic                v1_reg, v2_reg, v3_reg;
    logic                f1_reg, f2_reg, f3_reg;
    logic [ADDR_W-1:0]   i1_reg, i2_reg, i3_reg;
    logic [SQ_W-1:0]     sqr_reg, sqg_reg, sqb_reg, sqa_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    best_dist_reg;
    logic [ADDR_W-1:0]   best_idx_reg;
    logic                out_valid_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic [DIST_W-1:0]   out_dist_reg;
    logic                take_best;
    logic                wr_in_range;

    assign wr_in_range = ({1'b0, entry_index} < (IDX_W + 1)'(PALETTE_DEPTH));
    assign pa_byte     = pixels_have_alpha ? pixel_alpha : '1;

    // palette memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_in_range)
            mem[entry_index[ADDR_W-1:0]] <= '{red: entry_red, green: entry_green,
                                              blue: entry_blue, alpha: entry_alpha};
        if (cmd.rd_en)
            rd_reg <= mem[cmd.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            pr_reg <= {pixel_red,   {FRACTION_BITS{1'b0}}};
            pg_reg <= {pixel_green, {FRACTION_BITS{1'b0}}};
            pb_reg <= {pixel_blue,  {FRACTION_BITS{1'b0}}};
            pa_reg <= {pa_byte,     {FRACTION_BITS{1'b0}}};
        end
        i1_reg  <= cmd.rd_addr;
        f1_reg  <= cmd.rd_first;
        i2_reg  <= i1_reg;
        f2_reg  <= f1_reg;
        i3_reg  <= i2_reg;
        f3_reg  <= f2_reg;
        sqr_reg <= sq_diff(DIFF_W'(pr_reg), DIFF_W'(rd_reg.red));
        sqg_reg <= sq_diff(DIFF_W'(pg_reg), DIFF_W'(rd_reg.green));
        sqb_reg <= sq_diff(DIFF_W'(pb_reg), DIFF_W'(rd_reg.blue));
        sqa_reg <= sq_diff(DIFF_W'(pa_reg), DIFF_W'(rd_reg.alpha));
        // weights 2, 4, 3 and 4 as shifts and adds
        sum_reg <= (SUM_W'(sqr_reg) << 1) + (SUM_W'(sqg_reg) << 2)
                 + (SUM_W'(sqb_reg) << 1) + SUM_W'(sqb_reg) + (SUM_W'(sqa_reg) << 2);
        if (take_best)
        begin
            best_dist_reg <= sum_reg;
            best_idx_reg  <= i3_reg;
        end
        if (cmd.out_load)
        begin
            out_idx_reg <= IDX_W'(best_idx_reg);
            if (SAT_W'(best_dist_reg) > SAT_W'(DIST_MAX))
                out_dist_reg <= DIST_MAX;
            else
                out_dist_reg <= DIST_W'(best_dist_reg);
        end
    end

    // strict less-than keeps the lowest index on a tie
    assign take_best = v3_reg && (f3_reg || (sum_reg < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= cmd.rd_en;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= cmd.out_load || (out_valid_reg && !out_ready);
        end
    end

    assign stat.out_free    = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign nearest_index    = out_idx_reg;
    assign nearest_distance = out_dist_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result word loaded over one not yet taken");

    a_no_read_during_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> !(cmd.rd_en || v1_reg || v2_reg || v3_reg))
        else $error("palette write during a scan");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready)
            |=> (out_valid_reg && $stable(out_idx_reg) && $stable(out_dist_reg)))
        else $error("result word changed while held off");

endmodule

// File: dv/palette_nearest_color_mapper_checker.sv
// Checker for the palette nearest colour mapper: keeps its own palette and register
// copies, predicts each pixel's nearest entry and compares the result words in order.
// Depends on pnc_pkg and pnc_if.
module palette_nearest_color_mapper_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    pnc_req_if                            req,
    pnc_rsp_if                            rsp,
    input  logic                          cfg_we,
    input  logic [pnc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pnc_pkg::CFG_W-1:0]     cfg_data,
    output int                            mismatches,
    output int                            outstanding,
    output int                            checked
);
    import pnc_pkg::*;

    localparam int unsigned WEIGHT_RED   = 2;
    localparam int unsigned WEIGHT_GREEN = 4;
    localparam int unsigned WEIGHT_BLUE  = 3;
    localparam int unsigned WEIGHT_ALPHA = 4;
    localparam logic [BYTE_W-1:0] OPAQUE = 8'd255;
    localparam logic [DIST_W-1:0] DIST_CEILING = '1;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] distance;
    } nearest_t;

    entry_t           palette [PALETTE_DEPTH];
    logic [CNT_W-1:0] active_count;
    logic             alpha_on;
    nearest_t         nearest_q [$];
    int               failures;
    int               compared;

    function automatic logic [SQ_W-1:0] sq_gap(input logic [DIFF_W-1:0] p,
                                               input logic [DIFF_W-1:0] q);
        logic [DIFF_W-1:0] gap;
        gap = (p >= q) ? p - q : q - p;
        return SQ_W'(gap) * SQ_W'(gap);
    endfunction

    function automatic nearest_t nearest_entry(input logic [BYTE_W-1:0] r, g, b, a);
        logic [PIX_W-1:0] pr, pg, pb, pa;
        int unsigned      searched;
        logic [39:0]      cand_dist;
        logic [39:0]      best_dist;
        nearest_t         found;
        pr = PIX_W'(r) << FRACTION_BITS;
        pg = PIX_W'(g) << FRACTION_BITS;
        pb = PIX_W'(b) << FRACTION_BITS;
        pa = PIX_W'(alpha_on ? a : OPAQUE) << FRACTION_BITS;
        // a count of zero searches one entry; anything past the store searches all
        searched = (active_count == 0) ? 1 :
                   (active_count > PALETTE_DEPTH) ? PALETTE_DEPTH : active_count;
        best_dist = '0;
        found.index = '0;
        for (int e = 0; e < searched; e++) begin
            cand_dist = WEIGHT_RED   * 40'(sq_gap(pr, palette[e].red))
                      + WEIGHT_GREEN * 40'(sq_gap(pg, palette[e].green))
                      + WEIGHT_BLUE  * 40'(sq_gap(pb, palette[e].blue))
                      + WEIGHT_ALPHA * 40'(sq_gap(pa, palette[e].alpha));
            // strict less-than: the lowest index wins a tie
            if (e == 0 || cand_dist < best_dist) begin
                best_dist = cand_dist;
                found.index = IDX_W'(e);
            end
        end
        found.distance = (best_dist > 40'(DIST_CEILING)) ? DIST_CEILING : DIST_W'(best_dist);
        return found;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        nearest_t seen;
        nearest_t wanted;
        if (!rst_n) begin
            active_count = CNT_W'(PALETTE_DEPTH);
            alpha_on = 1'b1;
            nearest_q.delete();
            failures = 0;
            compared = 0;
        end else begin
            // results first: a word leaving at this edge belongs to an earlier pixel
            if (rsp.valid && rsp.ready) begin
                seen.index = rsp.nearest_index;
                seen.distance = rsp.nearest_distance;
                if (nearest_q.size() == 0) begin
                    $error("result word with nothing expected: nearest_index %0d, nearest_distance %0d",
                           seen.index, seen.distance);
                    failures++;
                end else begin
                    wanted = nearest_q.pop_front();
                    compared++;
                    if (seen.index !== wanted.index) begin
                        $error("nearest_index: expected %0d, actual %0d",
                               wanted.index, seen.index);
                        failures++;
                    end
                    if (seen.distance !== wanted.distance) begin
                        $error("nearest_distance: expected %0d, actual %0d",
                               wanted.distance, seen.distance);
                        failures++;
                    end
                end
            end
            if (req.valid && req.ready) begin
                // an 8-bit index always lands inside the store
                if (req.kind == KIND_WRITE)
                    palette[req.entry_index] = '{req.entry_red, req.entry_green,
                                                 req.entry_blue, req.entry_alpha};
                else
                    nearest_q = {nearest_q, nearest_entry(req.pixel_red, req.pixel_green,
                                                          req.pixel_blue, req.pixel_alpha)};
            end
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_ACTIVE_ENTRIES:    active_count = cfg_data[CNT_W-1:0];
                    REG_PIXELS_HAVE_ALPHA: alpha_on = cfg_data[0];
                    default: ;
                endcase
            end
        end
        mismatches  <= failures;
        outstanding <= nearest_q.size();
        checked     <= compared;
    end

endmodule

// File: dv/palette_nearest_color_mapper_test.sv
// Testbench top for the palette nearest colour mapper: drives palette and pixel words,
// register settings and result back-pressure; the checker module does the comparing.
// Depends on pnc_pkg, pnc_if, the block and palette_nearest_color_mapper_checker.
module palette_nearest_color_mapper_test;
    import pnc_pkg::*;

    localparam int TOTAL_WORDS    = 1350;
    localparam int QUIET_TAIL     = 150;
    localparam int SETTLE_CYCLES  = DRAIN_CYCLES + 8;
    localparam int END_CYCLES     = 32;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_CFG        = (1 << CFG_W) - 1;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
    } pixel_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    cfg_reg_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               mismatches;
    int               outstanding;
    int               checked;

    pnc_req_if req_ch ();
    pnc_rsp_if rsp_ch ();

    // stimulus bookkeeping: which entries hold data, and what they hold
    bit          written [PALETTE_DEPTH];
    entry_t      shadow [PALETTE_DEPTH];
    int          written_prefix;
    int unsigned searched_now;
    int          words_sent;
    int          writes_sent;
    int          pixels_sent;
    int          settings_used;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          no_idling;
    bit          long_hold;

    palette_nearest_color_mapper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    palette_nearest_color_mapper_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [CHAN_W-1:0] pick_channel();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return {BYTE_W'($urandom), {FRACTION_BITS{1'b0}}};
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    function automatic entry_t pick_entry();
        entry_t e;
        // copy a stored entry now and then to provoke ties
        if (written_prefix > 0 && $urandom_range(0, 4) == 0)
            return shadow[$urandom_range(0, written_prefix - 1)];
        e.red   = pick_channel();
        e.green = pick_channel();
        e.blue  = pick_channel();
        e.alpha = pick_channel();
        return e;
    endfunction

    function automatic pixel_t pick_pixel();
        pixel_t px;
        entry_t near;
        near = shadow[$urandom_range(0, searched_now - 1)];
        px = pixel_t'($urandom);
        case ($urandom_range(0, 4))
            1: px = '{$urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                      $urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00};
            2: px = '{near.red[CHAN_W-1 -: BYTE_W], near.green[CHAN_W-1 -: BYTE_W],
                      near.blue[CHAN_W-1 -: BYTE_W], near.alpha[CHAN_W-1 -: BYTE_W]};
            3: begin
                px.red   = near.red[CHAN_W-1 -: BYTE_W] + BYTE_W'($urandom_range(0, 4)) - 8'd2;
                px.green = near.green[CHAN_W-1 -: BYTE_W] + BYTE_W'($urandom_range(0, 4)) - 8'd2;
                px.blue  = near.blue[CHAN_W-1 -: BYTE_W] + BYTE_W'($urandom_range(0, 4)) - 8'd2;
                px.alpha = near.alpha[CHAN_W-1 -: BYTE_W] + BYTE_W'($urandom_range(0, 4)) - 8'd2;
            end
            default: ;
        endcase
        return px;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // offer one word, hold it until taken, then maybe drop valid for a burst
    task automatic send_word(input kind_t kind, input logic [IDX_W-1:0] index,
                             input entry_t entry, input pixel_t px);
        int gap;
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= kind;
        req_ch.entry_index <= index;
        req_ch.entry_red   <= entry.red;
        req_ch.entry_green <= entry.green;
        req_ch.entry_blue  <= entry.blue;
        req_ch.entry_alpha <= entry.alpha;
        req_ch.pixel_red   <= px.red;
        req_ch.pixel_green <= px.green;
        req_ch.pixel_blue  <= px.blue;
        req_ch.pixel_alpha <= px.alpha;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        words_sent++;
        if (kind == KIND_WRITE) begin
            written[index] = 1'b1;
            shadow[index] = entry;
            while (written_prefix < PALETTE_DEPTH && written[written_prefix])
                written_prefix++;
            writes_sent++;
        end else begin
            pixels_sent++;
        end
        if (!no_idling && $urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 13);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_entry(input logic [IDX_W-1:0] index, input entry_t entry);
        send_word(KIND_WRITE, index, entry, pixel_t'($urandom));
    endtask

    task automatic send_pixel(input pixel_t px);
        send_word(KIND_PIXEL, IDX_W'($urandom), pick_entry(), px);
    endtask

    // hold the sender until every result is back and the block has settled
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] active, input logic [CFG_W-1:0] alpha_word);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_ACTIVE_ENTRIES;
        cfg_data  <= active;
        @(posedge clk);
        cfg_index <= REG_PIXELS_HAVE_ALPHA;
        cfg_data  <= alpha_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        searched_now = (active == 0) ? 1 : (active > PALETTE_DEPTH) ? PALETTE_DEPTH : active;
        settings_used++;
    endtask

    // result side: random stall bursts, plus one long hold on request
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (long_hold) begin
                long_hold = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !no_idling &&
                         $urandom_range(0, 99) < recv_idle_pct) begin
                stall_left = $urandom_range(1, 13);
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int               phase;
        int               phase_len;
        int               write_pct;
        logic [CFG_W-1:0] active;
        logic [IDX_W-1:0] index;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_ACTIVE_ENTRIES;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.kind        <= KIND_WRITE;
        req_ch.entry_index <= '0;
        req_ch.entry_red   <= '0;
        req_ch.entry_green <= '0;
        req_ch.entry_blue  <= '0;
        req_ch.entry_alpha <= '0;
        req_ch.pixel_red   <= '0;
        req_ch.pixel_green <= '0;
        req_ch.pixel_blue  <= '0;
        req_ch.pixel_alpha <= '0;
        written_prefix = 0;
        searched_now   = 1;
        words_sent     = 0;
        writes_sent    = 0;
        pixels_sent    = 0;
        settings_used  = 0;
        send_idle_pct  = 20;
        recv_idle_pct  = 20;
        no_idling      = 1'b0;
        long_hold      = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: channel extremes, ties, alpha off, single-entry and zero counts
        configure(9'd1, 9'd1);
        write_entry(8'd0, '0);
        send_pixel('0);
        send_pixel('1);
        write_entry(8'd0, '1);
        send_pixel('0);
        send_pixel('1);
        write_entry(8'd1, '0);
        write_entry(8'd2, '0);
        write_entry(8'd255, '{12'hFFF, 12'h000, 12'hFFF, 12'h000});
        configure(9'd3, 9'd0);
        send_pixel('0);
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd0});
        send_pixel('{8'd0, 8'd1, 8'd128, 8'd7});
        configure(9'd0, 9'h1FF);
        send_pixel('{8'd1, 8'd2, 8'd3, 8'd4});
        send_pixel('1);

        // random phases, each under its own register setting
        phase = 0;
        while (words_sent < TOTAL_WORDS) begin
            case ($urandom_range(0, 19))
                0:       active = '0;
                1:       active = (written_prefix == PALETTE_DEPTH) ?
                                  ($urandom_range(0, 1) ? CFG_W'(MAX_CFG) :
                                   CFG_W'($urandom_range(PALETTE_DEPTH + 1, MAX_CFG))) : 9'd1;
                2, 3:    active = CFG_W'(written_prefix);
                4:       active = CFG_W'($urandom_range(1, written_prefix));
                default: active = CFG_W'($urandom_range(1, (written_prefix < 24) ?
                                                            written_prefix : 24));
            endcase
            // keep the search short while the result side is held off
            if (phase == 2)
                active = 9'd2;
            configure(active, CFG_W'($urandom));
            send_idle_pct = pick_idle_pct();
            recv_idle_pct = pick_idle_pct();
            if (phase == 2)
                long_hold = 1'b1;
            write_pct = (written_prefix < PALETTE_DEPTH) ? 60 : 20;
            phase_len = $urandom_range(20, 80);
            for (int n = 0; n < phase_len && words_sent < TOTAL_WORDS; n++) begin
                no_idling = (words_sent >= TOTAL_WORDS - QUIET_TAIL);
                if ($urandom_range(0, 99) < write_pct) begin
                    // mostly grow the written prefix so larger counts become legal
                    index = (written_prefix < PALETTE_DEPTH && $urandom_range(0, 4) != 0) ?
                            IDX_W'(written_prefix) : IDX_W'($urandom);
                    write_entry(index, pick_entry());
                end else begin
                    send_pixel(pick_pixel());
                end
            end
            phase++;
        end

        drain();
        repeat (END_CYCLES) @(posedge clk);
        $display("Sent %0d words (%0d palette writes, %0d pixels) across %0d register settings.",
                 words_sent, writes_sent, pixels_sent, settings_used);
        $display("Compared %0d nearest-entry results; %0d mismatches.", checked, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
